// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files of the YUYV blit core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked check, disabled while reset is asserted.
`define YUYV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("yuyv assertion failed");

// Clocked implication check, disabled while reset is asserted.
`define YUYV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("yuyv assertion failed");

`else

`define YUYV_ASSERT(lbl, prop)
`define YUYV_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

// ===== src/yuyv_pkg.sv =====
// Shared types and constants of the YUYV422 to RGB888 blit core.
package yuyv_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_X     = 3'd2;
  localparam logic [2:0] CFG_ORIGIN_Y     = 3'd3;
  localparam logic [2:0] CFG_LINE_STRIDE  = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [15:0] LINE_STRIDE_RST  = 16'd2560;

  // Framebuffer geometry
  localparam int BPP_SHIFT   = 2;   // four bytes per pixel
  localparam int ADDR_BITS   = 26;
  localparam int ADDR_SUM_W  = 30;  // wide enough for the unreduced offset

  // Decoupling queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // Item handed from the front to the back
  typedef struct packed {
    logic [7:0]  luma_first;
    logic [7:0]  chroma_blue;
    logic [7:0]  luma_second;
    logic [7:0]  chroma_red;
    logic [10:0] col;
    logic [11:0] row;
    logic        eor;
    logic        eof;
  } yuyv_item_t;

  // Placement registers used by the back
  typedef struct packed {
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [15:0] line_stride;
  } yuyv_place_t;

endpackage

// ===== src/yuyv422_to_rgb888_blit_core.sv =====
// Top level of the YUYV422 to RGB888 blit core.
// Usage:
//   in_*   : one YUYV422 group per item (Y0, U, Y1, V), raster order.
//   out_*  : two RGB888 pixels per item plus the framebuffer byte offset of
//            the left pixel; out_tlast marks the last pair of a camera line,
//            out_tuser carries the address overflow flag and end of frame.
//   cfg_*  : register writes (frame width/height, origin x/y, line stride);
//            user must write only while no item is in flight (not enforced).
// Throughput is one item per clock while the queue has room. An accepted item
// is classified by the pair/line counters, waits in a four-entry queue and
// then goes through a multiply stage and an add/clamp stage into the output
// register. The output register and the queue let in_tready stay high while
// a result waits; in_tready drops only once the queue is full behind a
// stalled receiver, and no item is lost or repeated.
// Reset (rst_n low, synchronous) restores the register defaults (640 x 480,
// origin 0, stride 2560), clears the counters, empties the queue and drops
// out_tvalid.
module yuyv422_to_rgb888_blit_core import yuyv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // luma_first[7:0], chroma_blue[15:8], luma_second[23:16], chroma_red[31:24]
  input  logic [31:0]           in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pixel_left[23:0], pixel_right[47:24], byte_address[73:48], zero[79:74]
  output logic [79:0]           out_tdata,
  // address_overflow[0], end_of_frame[1]
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  logic                 push;
  yuyv_item_t           push_item;
  yuyv_place_t          place;
  logic                 pop;
  logic                 q_valid;
  yuyv_item_t           q_item;
  logic [23:0]          pixel_left;
  logic [23:0]          pixel_right;
  logic [ADDR_BITS-1:0] byte_address;
  logic                 address_overflow;
  logic                 end_of_row;
  logic                 end_of_frame;

  yuyv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .q_ready   (in_tready),
    .push      (push),
    .push_item (push_item),
    .place     (place)
  );

  yuyv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (in_tready),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_item   (q_item)
  );

  yuyv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .pop              (pop),
    .place            (place),
    .out_ready        (out_tready),
    .out_valid        (out_tvalid),
    .pixel_left       (pixel_left),
    .pixel_right      (pixel_right),
    .byte_address     (byte_address),
    .address_overflow (address_overflow),
    .end_of_row       (end_of_row),
    .end_of_frame     (end_of_frame)
  );

  // Pack result fields onto the stream
  assign out_tdata = {6'd0, byte_address, pixel_right, pixel_left};
  assign out_tuser = {end_of_frame, address_overflow};
  assign out_tlast = end_of_row;

endmodule

// ===== src/yuyv_front.sv =====
// Front part: configuration registers, pair/line counters and item classification.
module yuyv_front import yuyv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic [31:0]           in_tdata,
  input  logic                  q_ready,
  output logic                  push,
  output yuyv_item_t            push_item,
  output yuyv_place_t           place
);

  logic [12:0] frame_width_r;
  logic [12:0] frame_height_r;
  logic [11:0] origin_x_r;
  logic [11:0] origin_y_r;
  logic [15:0] line_stride_r;
  logic [10:0] col_r, col_nxt;
  logic [11:0] row_r, row_nxt;
  logic [11:0] half_width;
  logic [11:0] pairs_m1;
  logic [11:0] lines_m1;
  logic        eor;
  logic        eof;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      line_stride_r  <= LINE_STRIDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[12:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[12:0];
        CFG_ORIGIN_X:     origin_x_r     <= cfg_wdata[11:0];
        CFG_ORIGIN_Y:     origin_y_r     <= cfg_wdata[11:0];
        CFG_LINE_STRIDE:  line_stride_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Last pair index per line, clamped to 1..2048 pairs
  assign half_width = frame_width_r[12:1];
  always_comb begin
    if (half_width == 12'd0) begin
      pairs_m1 = 12'd0;
    end else if (half_width > 12'd2048) begin
      pairs_m1 = 12'd2047;
    end else begin
      pairs_m1 = half_width - 12'd1;
    end
  end

  // Last line index, clamped to 1..4096 lines
  always_comb begin
    if (frame_height_r == 13'd0) begin
      lines_m1 = 12'd0;
    end else if (frame_height_r > 13'd4096) begin
      lines_m1 = 12'd4095;
    end else begin
      lines_m1 = 12'(frame_height_r - 13'd1);
    end
  end

  // Classify the current pair
  assign eor = {1'b0, col_r} >= pairs_m1;
  assign eof = eor && (row_r >= lines_m1);

  // Advance counters, wrapping at end of row and end of frame
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (push) begin
      if (eor) begin
        col_nxt = '0;
        row_nxt = eof ? '0 : row_r + 12'd1;
      end else begin
        col_nxt = col_r + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign push = in_tvalid && q_ready;

  always_comb begin
    push_item.luma_first  = in_tdata[7:0];
    push_item.chroma_blue = in_tdata[15:8];
    push_item.luma_second = in_tdata[23:16];
    push_item.chroma_red  = in_tdata[31:24];
    push_item.col         = col_r;
    push_item.row         = row_r;
    push_item.eor         = eor;
    push_item.eof         = eof;
  end

  always_comb begin
    place.origin_x    = origin_x_r;
    place.origin_y    = origin_y_r;
    place.line_stride = line_stride_r;
  end

endmodule

// ===== src/yuyv_queue.sv =====
// Short FIFO that decouples the front from the back.
`include "assert_macros.svh"
module yuyv_queue import yuyv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  yuyv_item_t push_item,
  output logic       push_ready,
  input  logic       pop,
  output logic       pop_valid,
  output yuyv_item_t pop_item
);

  yuyv_item_t        store_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign push_ready = cnt_r != QCNT_W'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_item   = store_r[rd_ptr_r];

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_item;
    end
  end

  // Track fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  `YUYV_ASSERT(a_cnt_in_range, cnt_r <= QCNT_W'(QDEPTH))
  `YUYV_ASSERT(a_pop_nonempty, !pop || (cnt_r != '0))
  `YUYV_ASSERT(a_push_not_full, !push || (cnt_r != QCNT_W'(QDEPTH)))
  `YUYV_ASSERT_IMP(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + QCNT_W'(1))
  `YUYV_ASSERT_IMP(a_ptr_gap, 1'b1,
                   QPTR_W'(wr_ptr_r - rd_ptr_r) == cnt_r[QPTR_W-1:0])

endmodule

// ===== src/yuyv_back.sv =====
// Back part: color conversion and framebuffer address, two registered stages.
module yuyv_back import yuyv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  yuyv_item_t           q_item,
  output logic                 pop,
  input  yuyv_place_t          place,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [23:0]          pixel_left,
  output logic [23:0]          pixel_right,
  output logic [ADDR_BITS-1:0] byte_address,
  output logic                 address_overflow,
  output logic                 end_of_row,
  output logic                 end_of_frame
);

  // Q16 coefficients
  localparam logic signed [17:0] K_R  = 18'sd92242;
  localparam logic signed [17:0] K_GU = 18'sd22643;
  localparam logic signed [17:0] K_GV = 18'sd46982;
  localparam logic signed [17:0] K_B  = 18'sd116589;

  function automatic logic [7:0] clamp_byte(input logic [11:0] v);
    logic [7:0] res;
    if (v[11]) begin
      res = 8'd0;
    end else if (v[10:8] != 3'd0) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  logic signed [7:0]  du, dv;
  logic signed [25:0] prod_r_c, prod_gu_c, prod_gv_c, prod_b_c;
  logic [12:0]        row_sum;
  logic [12:0]        col_sum;
  logic [28:0]        row_prod_c;

  logic               s1_vld_r;
  logic [7:0]         s1_y0_r, s1_y1_r;
  logic [9:0]         s1_tr_r, s1_tgu_r, s1_tgv_r, s1_tb_r;
  logic [28:0]        s1_row_prod_r;
  logic [14:0]        s1_col_term_r;
  logic               s1_eor_r, s1_eof_r;
  logic               s1_en;
  logic               out_free;

  logic [11:0]        tr_x, tb_x, tg_x;
  logic [11:0]        y0_x, y1_x;
  logic [23:0]        pix_l_c, pix_r_c;
  logic [ADDR_SUM_W-1:0] addr_sum;
  logic               out_vld_r;

  // Stage handshake: a stage loads when it is empty or its successor moves
  assign out_free = !out_vld_r || out_ready;
  assign s1_en    = !s1_vld_r || out_free;
  assign pop      = q_valid && s1_en;

  // Stage 1: chroma products and address terms
  assign du = {~q_item.chroma_blue[7], q_item.chroma_blue[6:0]};
  assign dv = {~q_item.chroma_red[7], q_item.chroma_red[6:0]};
  assign prod_r_c  = 26'(K_R)  * 26'(dv);
  assign prod_gu_c = 26'(K_GU) * 26'(du);
  assign prod_gv_c = 26'(K_GV) * 26'(dv);
  assign prod_b_c  = 26'(K_B)  * 26'(du);

  assign row_sum    = {1'b0, place.origin_y} + {1'b0, q_item.row};
  assign col_sum    = {1'b0, place.origin_x} + {1'b0, q_item.col, 1'b0};
  assign row_prod_c = 29'(row_sum) * 29'(place.line_stride);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_en) begin
      s1_vld_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_y0_r       <= q_item.luma_first;
      s1_y1_r       <= q_item.luma_second;
      s1_tr_r       <= prod_r_c[25:16];
      s1_tgu_r      <= prod_gu_c[25:16];
      s1_tgv_r      <= prod_gv_c[25:16];
      s1_tb_r       <= prod_b_c[25:16];
      s1_row_prod_r <= row_prod_c;
      s1_col_term_r <= {col_sum, {BPP_SHIFT{1'b0}}};
      s1_eor_r      <= q_item.eor;
      s1_eof_r      <= q_item.eof;
    end
  end

  // Stage 2: add luma, clamp, finish the address
  assign tr_x = {{2{s1_tr_r[9]}}, s1_tr_r};
  assign tb_x = {{2{s1_tb_r[9]}}, s1_tb_r};
  assign tg_x = {{2{s1_tgu_r[9]}}, s1_tgu_r} + {{2{s1_tgv_r[9]}}, s1_tgv_r};
  assign y0_x = {4'd0, s1_y0_r};
  assign y1_x = {4'd0, s1_y1_r};

  assign pix_l_c = {clamp_byte(y0_x + tr_x), clamp_byte(y0_x - tg_x),
                    clamp_byte(y0_x + tb_x)};
  assign pix_r_c = {clamp_byte(y1_x + tr_x), clamp_byte(y1_x - tg_x),
                    clamp_byte(y1_x + tb_x)};
  assign addr_sum = ADDR_SUM_W'(s1_row_prod_r) + ADDR_SUM_W'(s1_col_term_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (out_free && s1_vld_r) begin
      pixel_left       <= pix_l_c;
      pixel_right      <= pix_r_c;
      byte_address     <= addr_sum[ADDR_BITS-1:0];
      address_overflow <= |addr_sum[ADDR_SUM_W-1:ADDR_BITS];
      end_of_row       <= s1_eor_r;
      end_of_frame     <= s1_eof_r;
    end
  end

  assign out_valid = out_vld_r;

endmodule

// ===== dv/yuyv_blit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the YUYV blit core: snoops the channels, predicts each pixel pair and compares.
module yuyv_blit_checker import yuyv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // luma_first[7:0], chroma_blue[15:8], luma_second[23:16], chroma_red[31:24]
  input  logic [31:0]           in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // pixel_left[23:0], pixel_right[47:24], byte_address[73:48], zero[79:74]
  input  logic [79:0]           out_tdata,
  // address_overflow[0], end_of_frame[1]
  input  logic [1:0]            out_tuser,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    pending_count,
  output int                    results_checked,
  output int                    frame_ends,
  output int                    overflow_hits
);

  // Q16 conversion coefficients
  localparam int COEF_R  = 92242;
  localparam int COEF_GU = 22643;
  localparam int COEF_GV = 46982;
  localparam int COEF_B  = 116589;
  localparam int CHROMA_OFFSET = 128;
  localparam longint ADDR_MASK = (longint'(1) << ADDR_BITS) - 1;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [23:0] pixel_left;
    logic [23:0] pixel_right;
    logic [25:0] byte_address;
    logic        address_overflow;
    logic        end_of_row;
    logic        end_of_frame;
  } pair_result_t;

  pair_result_t expected_pairs[$];

  // Shadow registers and raster counters
  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [11:0] origin_x;
  logic [11:0] origin_y;
  logic [15:0] line_stride;
  logic [10:0] pair_column;
  logic [11:0] line_row;

  function automatic logic [7:0] clamp_level(input int level);
    if (level < 0) return 8'd0;
    if (level > 255) return 8'd255;
    return level[7:0];
  endfunction

  // Convert one group at the current raster position
  function automatic pair_result_t convert_group(input logic [31:0] group);
    int luma0, luma1, du, dv, red_off, green_off, blue_off;
    int pairs, lines;
    longint offset;
    pair_result_t res;
    luma0 = int'(group[7:0]);
    du    = int'(group[15:8]) - CHROMA_OFFSET;
    luma1 = int'(group[23:16]);
    dv    = int'(group[31:24]) - CHROMA_OFFSET;
    red_off   = (COEF_R * dv) >>> 16;
    green_off = ((COEF_GU * du) >>> 16) + ((COEF_GV * dv) >>> 16);
    blue_off  = (COEF_B * du) >>> 16;
    res.pixel_left  = {clamp_level(luma0 + red_off), clamp_level(luma0 - green_off),
                       clamp_level(luma0 + blue_off)};
    res.pixel_right = {clamp_level(luma1 + red_off), clamp_level(luma1 - green_off),
                       clamp_level(luma1 + blue_off)};
    // Exact offset, then reduce to the address width
    offset = (longint'(origin_y) + longint'(line_row)) * longint'(line_stride)
           + (longint'(origin_x) + 2 * longint'(pair_column)) * (longint'(1) << BPP_SHIFT);
    res.byte_address     = offset[25:0];
    res.address_overflow = offset > ADDR_MASK;
    // Degenerate and oversized geometry saturates
    pairs = int'(frame_width) >> 1;
    if (pairs < 1) pairs = 1;
    if (pairs > 2048) pairs = 2048;
    lines = int'(frame_height);
    if (lines < 1) lines = 1;
    if (lines > 4096) lines = 4096;
    res.end_of_row   = int'(pair_column) >= pairs - 1;
    res.end_of_frame = res.end_of_row && int'(line_row) >= lines - 1;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < MAX_PRINTED)
      $display("%0t ns: result %0d %s: got %h, want %h", $time, results_checked,
               field, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pair_result_t want;
    pair_result_t got;
    if (!rst_n) begin
      frame_width   = FRAME_WIDTH_RST;
      frame_height  = FRAME_HEIGHT_RST;
      origin_x      = '0;
      origin_y      = '0;
      line_stride   = LINE_STRIDE_RST;
      pair_column   = '0;
      line_row      = '0;
      expected_pairs.delete();
      fail_count      = 0;
      results_checked = 0;
      frame_ends      = 0;
      overflow_hits   = 0;
    end else begin
      // Compare the result item against the oldest expectation
      if (out_tvalid && out_tready) begin
        got = {out_tdata[23:0], out_tdata[47:24], out_tdata[73:48],
               out_tuser[0], out_tlast, out_tuser[1]};
        if (expected_pairs.size() == 0) begin
          report_mismatch("with nothing expected", out_tdata[31:0], '0);
        end else begin
          want = expected_pairs.pop_front();
          if (got.pixel_left != want.pixel_left)
            report_mismatch("pixel_left", got.pixel_left, want.pixel_left);
          if (got.pixel_right != want.pixel_right)
            report_mismatch("pixel_right", got.pixel_right, want.pixel_right);
          if (got.byte_address != want.byte_address)
            report_mismatch("byte_address", got.byte_address, want.byte_address);
          if (got.address_overflow != want.address_overflow)
            report_mismatch("address_overflow", got.address_overflow,
                            want.address_overflow);
          if (got.end_of_row != want.end_of_row)
            report_mismatch("end_of_row", got.end_of_row, want.end_of_row);
          if (got.end_of_frame != want.end_of_frame)
            report_mismatch("end_of_frame", got.end_of_frame, want.end_of_frame);
          frame_ends    += want.end_of_frame;
          overflow_hits += want.address_overflow;
          results_checked++;
        end
      end
      // Predict the accepted item and advance the raster
      if (in_tvalid && in_tready) begin
        want = convert_group(in_tdata);
        expected_pairs.push_back(want);
        if (want.end_of_row) begin
          pair_column = '0;
          line_row    = want.end_of_frame ? '0 : line_row + 12'd1;
        end else begin
          pair_column = pair_column + 11'd1;
        end
      end
      // Track register writes; unmapped indexes drop
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width  = cfg_wdata[12:0];
          CFG_FRAME_HEIGHT: frame_height = cfg_wdata[12:0];
          CFG_ORIGIN_X:     origin_x     = cfg_wdata[11:0];
          CFG_ORIGIN_Y:     origin_y     = cfg_wdata[11:0];
          CFG_LINE_STRIDE:  line_stride  = cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
    pending_count = expected_pairs.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the YUYV blit core: clock, reset, stimulus, flow control and verdict.
module tb import yuyv_pkg::*;;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_BASE = 3'd5;
  localparam int IDLE_PCT      = 32;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [31:0]           in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [79:0]           out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  logic no_idle;
  logic hold_request;
  int   fail_count, pending_count, results_checked, frame_ends, overflow_hits;
  int   groups_sent, settings_used;

  yuyv422_to_rgb888_blit_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  yuyv_blit_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked),
    .frame_ends      (frame_ends),
    .overflow_hits   (overflow_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("yuyv422_to_rgb888_blit_core: mismatch");
    $finish;
  end

  // Receiver: random backpressure, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        for (int n = 1; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Bias luma and chroma toward the clamp extremes now and then
  function automatic logic [7:0] rand_level();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Offer one group; return at the edge that accepts it
  task automatic send_group(input logic [31:0] group);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= group;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    groups_sent++;
  endtask

  task automatic send_random_groups(input int count);
    repeat (count) send_group({rand_level(), rand_level(), rand_level(), rand_level()});
  endtask

  // Stop offering and wait until every pair has come back
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Load a full frame setting while idle; also poke an unmapped index
  task automatic program_frame(input int width, input int height, input int org_x,
                               input int org_y, input int stride);
    drain_pipe();
    write_reg(CFG_FRAME_WIDTH, width);
    write_reg(CFG_FRAME_HEIGHT, height);
    write_reg(CFG_ORIGIN_X, org_x);
    write_reg(CFG_ORIGIN_Y, org_y);
    write_reg(CFG_LINE_STRIDE, stride);
    write_reg(CFG_IDX_W'(CFG_UNMAPPED_BASE + $urandom_range(2)), $urandom_range(65535));
    settings_used++;
  endtask

  initial begin
    // Group layout: V, Y1, U, Y0 from the top byte down
    logic [31:0] corner_groups [18];
    int width, height;
    corner_groups = '{32'h00000000, 32'hFFFFFFFF, 32'h80FF8000, 32'h800080FF,
                      32'h00FFFF00, 32'hFF0000FF, 32'h00800080, 32'hFF80FF80,
                      32'h80EB8010, 32'hFFFF0000, 32'h0000FFFF, 32'h81FE7F01,
                      32'hF01E3CC8, 32'h226EF05A, 32'h7F807F80, 32'h01FF0100,
                      32'hAA55AA55, 32'h55AA55AA};
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    groups_sent  = 0;
    settings_used = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Chroma and luma corners under the reset geometry
    foreach (corner_groups[i]) send_group(corner_groups[i]);

    // Far corner origin with the widest stride: addresses overflow
    program_frame(4, 3, 4095, 4095, 65535);
    send_random_groups(40);
    // Width below two and zero height: every pair ends the frame
    program_frame(1, 0, 17, 9, 4);
    send_random_groups(10);
    program_frame(0, 1, 0, 4095, 0);
    send_random_groups(6);
    // Odd width rounds down to three pairs
    program_frame(7, 2, 3, 5, 40);
    send_random_groups(24);
    // Oversized geometry saturates
    program_frame(8191, 8191, 4095, 0, 65532);
    send_random_groups(20);
    program_frame(4096, 4096, 0, 0, 16384);
    send_random_groups(16);

    // Shrink the width mid-row: the column is already past the new end
    program_frame(16, 4, 10, 20, 256);
    send_random_groups(5);
    drain_pipe();
    write_reg(CFG_FRAME_WIDTH, 6);
    send_random_groups(3);
    // Restart the raster, then shrink the height mid-frame
    program_frame(2, 0, 0, 0, 64);
    send_random_groups(1);
    program_frame(4, 8, 100, 200, 1024);
    send_random_groups(7);
    drain_pipe();
    write_reg(CFG_FRAME_HEIGHT, 2);
    send_random_groups(5);

    // Full-rate stretch with no idling on either side
    program_frame(10, 3, 640, 480, 8192);
    no_idle = 1'b1;
    send_random_groups(100);
    // Receiver holds off while the sender keeps offering
    hold_request = 1'b1;
    send_random_groups(80);
    drain_pipe();
    no_idle = 1'b0;

    // Random geometry, mostly small frames
    for (int p = 0; p < 8; p++) begin
      width  = ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(2, 24);
      height = ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(5);
      program_frame(width, height, $urandom_range(4095), $urandom_range(4095),
                    $urandom_range(65535));
      send_random_groups($urandom_range(30, 70));
    end

    drain_pipe();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d YUYV groups across %0d register settings, incl. corner chroma",
             groups_sent, settings_used);
    $display("Checked %0d pixel pairs: %0d frame ends, %0d address overflows",
             results_checked, frame_ends, overflow_hits);
    if (fail_count == 0 && pending_count == 0) begin
      $display("yuyv422_to_rgb888_blit_core: match");
    end else begin
      $display("yuyv422_to_rgb888_blit_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/yuyv_pkg.sv
src/yuyv_front.sv
src/yuyv_queue.sv
src/yuyv_back.sv
src/yuyv422_to_rgb888_blit_core.sv
dv/yuyv_blit_checker.sv
dv/tb.sv
